// File: rtl/hsd_pkg.sv
// Shared types, constants and helper functions for the hall sector decoder.
package hsd_pkg;

  localparam int HALL_W = 3;
  localparam int SECTOR_W = 3;
  localparam int PERIOD_W = 16;
  localparam int TIME_W = 32;
  localparam int PROFILE_W = 2;
  localparam int OFFSET_W = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int IN_TDATA_W = 88;
  localparam int OUT_TDATA_W = 64;

  localparam logic [2:0] NO_SECTOR = 3'd7;
  localparam logic [HALL_W-1:0] HALL_MASK = 3'h7;
  localparam logic [SECTOR_W-1:0] SECTOR_COUNT = 3'd6;
  localparam logic [SECTOR_W-1:0] HALF_TURN = 3'd3;

  typedef enum logic {
    CMD_EDGE    = 1'b0,
    CMD_RESOLVE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROFILE_SELECT = 3'd0,
    REG_POLARITY_MASK  = 3'd1,
    REG_SECTOR_OFFSET  = 3'd2,
    REG_REVERSE_DRIVE  = 3'd3,
    REG_MIN_CHANGE     = 3'd4,
    REG_HOLD_TIMEOUT   = 3'd5
  } cfg_reg_t;

  // hall code to sector, one row per profile; NO_SECTOR marks illegal codes
  localparam logic [SECTOR_W-1:0] SECTOR_TABLE [4][8] = '{
    '{NO_SECTOR, 3'd0, 3'd4, 3'd5, 3'd2, 3'd1, 3'd3, NO_SECTOR},
    '{NO_SECTOR, 3'd0, 3'd2, 3'd1, 3'd4, 3'd5, 3'd3, NO_SECTOR},
    '{NO_SECTOR, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd5, NO_SECTOR},
    '{NO_SECTOR, 3'd2, 3'd4, 3'd3, 3'd0, 3'd1, 3'd5, NO_SECTOR}
  };

  // reduce a value in 0..29 modulo six
  function automatic logic [SECTOR_W-1:0] mod6(input logic [5:0] v);
    logic [5:0] r;
    begin
      r = v;
      if (r >= 6'd24) begin
        r = r - 6'd24;
      end else if (r >= 6'd18) begin
        r = r - 6'd18;
      end else if (r >= 6'd12) begin
        r = r - 6'd12;
      end else if (r >= 6'd6) begin
        r = r - 6'd6;
      end
      mod6 = r[SECTOR_W-1:0];
    end
  endfunction

  // ticks times 80, modulo 2^32
  function automatic logic [TIME_W-1:0] ticks_to_us(input logic [TIME_W-1:0] t);
    begin
      ticks_to_us = (t << 6) + (t << 4);
    end
  endfunction

endpackage

// File: rtl/hall_sector_decoder.sv
// Hall sector decoder top level: input register, decode logic and result register.
//
// Usage:
//   in_*  : request stream. in_tuser is the command (0 hall edge, 1 resolve query),
//           in_tdata carries hall bits, capture period, tick count and query time.
//   out_* : one result per request: accepted and drive sectors, stale flag and the
//           fields of the last edge.
//   cfg_* : register writes, always ready; write only while no request is in flight.
// Path: input register, then decode logic, then the result register driving out_*.
// Throughput: one request per cycle while out_tready is high; the decode, debounce
//   and timeout compares sit in one stage between the input and result registers.
// Stall: while out_tready is low the result holds; one more request can wait in
//   the input register, after that in_tready drops until the result is taken.
// Reset (rst_n low, synchronous): registers return to defaults, no sector is held,
//   stale is set and both stages are empty.
module hall_sector_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  // cfg_index: register index, cfg_data: write value
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hsd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata: hall_bits[2:0], capture_period[18:3], tick_count[50:19],
  //           now_us[82:51], zero[87:83]
  input  logic [hsd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: cmd[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata: accepted_sector[2:0], accepted_valid[3], drive_sector[6:4],
  //            stale[7], corrected_bits[10:8], mapped_sector[13:11],
  //            mapped_valid[14], edge_time_us[46:15], sector_period_us[62:47],
  //            zero[63]
  output logic [hsd_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  // configuration
  logic [hsd_pkg::PROFILE_W-1:0] profile_r;
  logic [hsd_pkg::HALL_W-1:0]    polarity_r;
  logic [hsd_pkg::OFFSET_W-1:0]  offset_r;
  logic                          reverse_r;
  logic [hsd_pkg::TIME_W-1:0]    min_change_r;
  logic [hsd_pkg::TIME_W-1:0]    hold_timeout_r;

  // input register
  logic                          in_valid_r;
  hsd_pkg::cmd_t                 in_cmd_r;
  logic [hsd_pkg::HALL_W-1:0]    in_hall_r;
  logic [hsd_pkg::PERIOD_W-1:0]  in_period_r;
  logic [hsd_pkg::TIME_W-1:0]    in_ticks_r;
  logic [hsd_pkg::TIME_W-1:0]    in_now_r;

  // decoder state
  logic [hsd_pkg::SECTOR_W-1:0]  held_sector_r, held_sector_nxt;
  logic                          held_valid_r, held_valid_nxt;
  logic [hsd_pkg::TIME_W-1:0]    held_change_r, held_change_nxt;
  logic [hsd_pkg::TIME_W-1:0]    last_ctrl_r, last_ctrl_nxt;
  logic [hsd_pkg::TIME_W-1:0]    event_time_r, event_time_nxt;
  logic                          stale_r, stale_nxt;
  logic [hsd_pkg::HALL_W-1:0]    last_corr_r, last_corr_nxt;
  logic [hsd_pkg::SECTOR_W-1:0]  last_mapped_r, last_mapped_nxt;
  logic                          last_mapped_valid_r, last_mapped_valid_nxt;
  logic [hsd_pkg::TIME_W-1:0]    last_edge_time_r, last_edge_time_nxt;
  logic [hsd_pkg::PERIOD_W-1:0]  last_period_r, last_period_nxt;

  // result register
  logic                          out_valid_r;
  logic [hsd_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                          advance;
  logic                          in_fire;
  logic [hsd_pkg::HALL_W-1:0]    corr;
  logic [hsd_pkg::SECTOR_W-1:0]  base;
  logic [5:0]                    offset_sum;
  logic [hsd_pkg::SECTOR_W-1:0]  mapped;
  logic [hsd_pkg::PERIOD_W-1:0]  period_f;
  logic [hsd_pkg::TIME_W-1:0]    since_change;
  logic [hsd_pkg::TIME_W-1:0]    age;
  logic [hsd_pkg::SECTOR_W-1:0]  acc_sector;
  logic [hsd_pkg::SECTOR_W-1:0]  drv_sector;
  logic [hsd_pkg::SECTOR_W:0]    drv_sum;

  assign cfg_ready  = 1'b1;
  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      profile_r      <= '0;
      polarity_r     <= '0;
      offset_r       <= '0;
      reverse_r      <= 1'b0;
      min_change_r   <= '0;
      hold_timeout_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (hsd_pkg::cfg_reg_t'(cfg_index))
        hsd_pkg::REG_PROFILE_SELECT: profile_r      <= cfg_data[hsd_pkg::PROFILE_W-1:0];
        hsd_pkg::REG_POLARITY_MASK:  polarity_r     <= cfg_data[hsd_pkg::HALL_W-1:0];
        hsd_pkg::REG_SECTOR_OFFSET:  offset_r       <= cfg_data[hsd_pkg::OFFSET_W-1:0];
        hsd_pkg::REG_REVERSE_DRIVE:  reverse_r      <= cfg_data[0];
        hsd_pkg::REG_MIN_CHANGE:     min_change_r   <= cfg_data;
        hsd_pkg::REG_HOLD_TIMEOUT:   hold_timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_cmd_r    <= hsd_pkg::cmd_t'(in_tuser);
      in_hall_r   <= in_tdata[2:0];
      in_period_r <= in_tdata[18:3];
      in_ticks_r  <= in_tdata[50:19];
      in_now_r    <= in_tdata[82:51];
    end
  end

  always_comb begin
    corr       = (in_hall_r ^ polarity_r) & hsd_pkg::HALL_MASK;
    base       = hsd_pkg::SECTOR_TABLE[profile_r][corr];
    offset_sum = {3'b000, base} + {{2{offset_r[hsd_pkg::OFFSET_W-1]}}, offset_r} + 6'd12;
    mapped     = hsd_pkg::mod6(offset_sum);
    period_f   = (in_period_r == '0) ? 16'd1 : in_period_r;
    event_time_nxt = event_time_r + {16'd0, period_f};
    since_change   = event_time_nxt - held_change_r;
    age            = in_now_r - last_ctrl_r;

    held_sector_nxt       = held_sector_r;
    held_valid_nxt        = held_valid_r;
    held_change_nxt       = held_change_r;
    last_ctrl_nxt         = last_ctrl_r;
    stale_nxt             = stale_r;
    last_corr_nxt         = last_corr_r;
    last_mapped_nxt       = last_mapped_r;
    last_mapped_valid_nxt = last_mapped_valid_r;
    last_edge_time_nxt    = last_edge_time_r;
    last_period_nxt       = last_period_r;

    case (in_cmd_r)
      hsd_pkg::CMD_EDGE: begin
        last_corr_nxt      = corr;
        last_edge_time_nxt = event_time_nxt;
        last_period_nxt    = period_f;
        if (base == hsd_pkg::NO_SECTOR) begin
          last_mapped_nxt       = '0;
          last_mapped_valid_nxt = 1'b0;
          stale_nxt             = 1'b1;
        end else begin
          last_mapped_nxt       = mapped;
          last_mapped_valid_nxt = 1'b1;
          last_ctrl_nxt         = hsd_pkg::ticks_to_us(in_ticks_r);
          stale_nxt             = 1'b0;
          if (!held_valid_r) begin
            held_sector_nxt = mapped;
            held_valid_nxt  = 1'b1;
            held_change_nxt = event_time_nxt;
          end else if (mapped != held_sector_r && since_change >= min_change_r) begin
            held_sector_nxt = mapped;
            held_change_nxt = event_time_nxt;
          end
        end
      end
      hsd_pkg::CMD_RESOLVE: begin
        if (held_valid_r) begin
          if (age > hold_timeout_r) begin
            held_valid_nxt = 1'b0;
            stale_nxt      = 1'b1;
          end
        end else begin
          stale_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    acc_sector = held_valid_nxt ? held_sector_nxt : '0;
    drv_sum    = {1'b0, acc_sector} + {1'b0, hsd_pkg::HALF_TURN};
    if (!reverse_r) begin
      drv_sector = acc_sector;
    end else if (drv_sum >= {1'b0, hsd_pkg::SECTOR_COUNT}) begin
      drv_sector = 3'(drv_sum - {1'b0, hsd_pkg::SECTOR_COUNT});
    end else begin
      drv_sector = drv_sum[hsd_pkg::SECTOR_W-1:0];
    end
    if (!held_valid_nxt) begin
      drv_sector = '0;
    end

    out_data_nxt = {1'b0, last_period_nxt, last_edge_time_nxt, last_mapped_valid_nxt,
                    last_mapped_nxt, last_corr_nxt, stale_nxt, drv_sector,
                    held_valid_nxt, acc_sector};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_sector_r       <= '0;
      held_valid_r        <= 1'b0;
      held_change_r       <= '0;
      last_ctrl_r         <= '0;
      event_time_r        <= '0;
      stale_r             <= 1'b1;
      last_corr_r         <= '0;
      last_mapped_r       <= '0;
      last_mapped_valid_r <= 1'b0;
      last_edge_time_r    <= '0;
      last_period_r       <= '0;
    end else if (advance) begin
      held_sector_r       <= held_sector_nxt;
      held_valid_r        <= held_valid_nxt;
      held_change_r       <= held_change_nxt;
      last_ctrl_r         <= last_ctrl_nxt;
      stale_r             <= stale_nxt;
      last_corr_r         <= last_corr_nxt;
      last_mapped_r       <= last_mapped_nxt;
      last_mapped_valid_r <= last_mapped_valid_nxt;
      last_edge_time_r    <= last_edge_time_nxt;
      last_period_r       <= last_period_nxt;
      if (in_cmd_r == hsd_pkg::CMD_EDGE) begin
        event_time_r <= event_time_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: rtl/hsd_checker.sv
// Port-level assertions for the hall sector decoder and their bind.
module hsd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hsd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [hsd_pkg::SECTOR_W-1:0] acc_sector;
  logic                         acc_valid;
  logic [hsd_pkg::SECTOR_W-1:0] drv_sector;
  logic                         stale;
  logic [hsd_pkg::SECTOR_W-1:0] map_sector;
  logic                         map_valid;

  assign acc_sector = out_tdata[2:0];
  assign acc_valid  = out_tdata[3];
  assign drv_sector = out_tdata[6:4];
  assign stale      = out_tdata[7];
  assign map_sector = out_tdata[13:11];
  assign map_valid  = out_tdata[14];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_no_held_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !acc_valid |-> acc_sector == '0 && drv_sector == '0 && stale)
    else $error("sector reported or stale clear without a held sector");

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && acc_valid |->
      acc_sector < hsd_pkg::SECTOR_COUNT && drv_sector < hsd_pkg::SECTOR_COUNT)
    else $error("held or drive sector out of range");

  a_map_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (map_valid && map_sector < hsd_pkg::SECTOR_COUNT) ||
                   (!map_valid && map_sector == '0))
    else $error("mapped sector inconsistent with its valid flag");

endmodule

bind hall_sector_decoder hsd_checker u_hsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
